// File: src/assert_macros.svh
// Assertion helpers used by the scanner RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising edge of clk, masked while rst is high.
`define ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequence checked in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/kdcs_pkg.sv
package kdcs_pkg;

  typedef logic [3:0] code_t;

  localparam code_t CODE_NONE  = 4'd0;
  localparam code_t CODE_WIFI  = 4'd3;
  localparam code_t CODE_TOTAL = 4'd4;
  localparam code_t CODE_TARE  = 4'd8;
  localparam code_t CODE_CHORD = 4'd9;

  typedef enum logic [1:0] {
    FUNC_TICK = 2'd0,
    FUNC_WAKE = 2'd1,
    FUNC_TAKE = 2'd2
  } func_t;

  typedef enum logic {
    CFG_DEBOUNCE = 1'b0,
    CFG_STUCK    = 1'b1
  } cfg_index_t;

  localparam logic [15:0] DEBOUNCE_RESET = 16'd40;
  localparam logic [31:0] STUCK_RESET    = 32'd15000;

  function automatic logic is_chord_part(code_t k);
    return (k == CODE_WIFI) || (k == CODE_TOTAL);
  endfunction

  function automatic logic held_off(code_t k, code_t supp);
    return (k == supp) || ((supp == CODE_CHORD) && is_chord_part(k));
  endfunction

  function automatic logic target_down(code_t target, logic [7:0] m);
    logic [2:0] idx;
    idx = 3'(target - 4'd1);
    if (target == CODE_NONE) return 1'b0;
    if (target == CODE_CHORD) return |m[3:2];
    if (target > CODE_TARE) return 1'b0;
    return m[idx];
  endfunction

  // Row-then-column priority scan; both row 1 keys together form the chord.
  function automatic code_t scan(logic [7:0] m, code_t supp);
    code_t k;
    code_t res;
    logic  found;
    res   = CODE_NONE;
    found = 1'b0;
    for (int r = 0; r < 4; r++) begin
      if (!found && r == 1 && m[3:2] == 2'b11 &&
          !held_off(CODE_WIFI, supp) && !held_off(CODE_TOTAL, supp)) begin
        res   = CODE_CHORD;
        found = 1'b1;
      end
      for (int c = 0; c < 2; c++) begin
        k = code_t'(r * 2 + c + 1);
        if (!found && m[r * 2 + c] && !held_off(k, supp)) begin
          res   = k;
          found = 1'b1;
        end
      end
    end
    return res;
  endfunction

endpackage

// File: src/keypad_debounce_chord_scanner_unit.sv
// Keypad scanner for a 4x2 matrix with debounce, chord key and stuck-key guard.
// Slave side: one command per transfer. tuser carries func (0 tick, 1 suppress
// the key held now, 2 take the pending event); tdata carries now_ms and the
// matrix snapshot. Master side: one result per command with the taken event,
// the debounced key and the suppression flag.
// Configuration: cfg_we, cfg_index and cfg_data write the debounce time (index 0,
// low 16 bits) or stuck_ms (index 1); write only while the block is idle.
// Throughput: one command per clock while the master side takes the results. The
// command lands in an input register, the whole update is one pass of compare
// and scan logic, and the result is then loaded into the result register, which
// drives m_tvalid.
// A stalled master side holds the result; one further command is still taken
// into the input register, after which s_tready drops until the result moves.
// Reset (rst, synchronous) empties both registers, clears all key state and
// loads a debounce time of 40 ms and stuck_ms = 15000.
module keypad_debounce_chord_scanner_unit
  import kdcs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // [31:0] now_ms, [39:32] matrix
  input  logic [1:0]  s_tuser,   // [1:0] func
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [3:0] event_code, [7:4] stable_code,
                                 // [8] suppress_active, [15:9] zero
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);

`include "assert_macros.svh"

  // Configuration
  logic [15:0] debounce_lim;
  logic [31:0] stuck_ms;

  // Input register
  logic        in_valid;
  logic [1:0]  in_func;
  logic [31:0] in_now;
  logic [7:0]  in_matrix;

  // Output register
  logic        out_valid;
  logic [8:0]  out_data;

  // Key state
  code_t       raw_last;
  logic [31:0] raw_time;
  code_t       stable;
  logic [31:0] stable_time;
  code_t       supp;
  logic [31:0] rel_time;
  code_t       pend;

  code_t       raw_last_next;
  logic [31:0] raw_time_next;
  code_t       stable_next;
  logic [31:0] stable_time_next;
  code_t       supp_next;
  logic [31:0] rel_time_next;
  code_t       pend_next;
  code_t       ev_next;

  logic        process;

  assign process  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || process;
  assign m_tvalid = out_valid;
  assign m_tdata  = {7'd0, out_data};

  always_comb begin
    code_t raw;
    code_t prev;
    code_t hold_key;
    logic  do_hold;

    raw_last_next    = raw_last;
    raw_time_next    = raw_time;
    stable_next      = stable;
    stable_time_next = stable_time;
    supp_next        = supp;
    rel_time_next    = rel_time;
    pend_next        = pend;
    ev_next          = CODE_NONE;
    raw              = CODE_NONE;
    prev             = CODE_NONE;
    hold_key         = CODE_NONE;
    do_hold          = 1'b0;

    unique case (in_func)
      FUNC_TICK: begin
        // Release tracking of the suppressed key; zero time means none seen.
        if (supp != CODE_NONE) begin
          if (target_down(supp, in_matrix)) begin
            rel_time_next = '0;
          end else if (rel_time == '0) begin
            rel_time_next = in_now;
          end else if ((in_now - rel_time) >= {16'd0, debounce_lim}) begin
            supp_next     = CODE_NONE;
            rel_time_next = '0;
          end
        end

        raw = scan(in_matrix, supp_next);
        if (raw != raw_last) begin
          raw_last_next = raw;
          raw_time_next = in_now;
        end

        if (raw != stable && (in_now - raw_time_next) >= {16'd0, debounce_lim}) begin
          prev             = stable;
          stable_next      = raw;
          stable_time_next = in_now;
          if (prev == CODE_CHORD) begin
            // Chord released: hold off both of its keys until let go
            supp_next     = CODE_CHORD;
            rel_time_next = '0;
            stable_next   = CODE_NONE;
            raw_last_next = CODE_NONE;
            raw_time_next = in_now;
            pend_next     = CODE_NONE;
          end else if (raw == CODE_NONE && is_chord_part(prev)) begin
            pend_next = prev;
          end else if (raw == CODE_CHORD && (prev == CODE_NONE || is_chord_part(prev))) begin
            pend_next = CODE_CHORD;
          end else if (prev == CODE_NONE && raw != CODE_NONE && !is_chord_part(raw)) begin
            pend_next = raw;
          end
        end

        if (stable_next != CODE_NONE && supp_next == CODE_NONE &&
            (in_now - stable_time_next) >= stuck_ms) begin
          do_hold  = 1'b1;
          hold_key = stable_next;
        end
      end
      FUNC_WAKE: begin
        do_hold  = 1'b1;
        hold_key = scan(in_matrix, supp);
      end
      FUNC_TAKE: begin
        ev_next   = pend;
        pend_next = CODE_NONE;
      end
      default: begin
      end
    endcase

    if (do_hold) begin
      supp_next        = is_chord_part(hold_key) ? CODE_CHORD : hold_key;
      rel_time_next    = '0;
      raw_last_next    = CODE_NONE;
      raw_time_next    = in_now;
      stable_next      = CODE_NONE;
      stable_time_next = in_now;
      pend_next        = CODE_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_lim <= DEBOUNCE_RESET;
      stuck_ms     <= STUCK_RESET;
      in_valid     <= 1'b0;
      out_valid    <= 1'b0;
      raw_last     <= CODE_NONE;
      raw_time     <= '0;
      stable       <= CODE_NONE;
      stable_time  <= '0;
      supp         <= CODE_NONE;
      rel_time     <= '0;
      pend         <= CODE_NONE;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_DEBOUNCE: debounce_lim <= cfg_data[15:0];
          CFG_STUCK:    stuck_ms     <= cfg_data;
          default:      ;
        endcase
      end

      if (s_tvalid && s_tready) begin
        in_valid <= 1'b1;
      end else if (process) begin
        in_valid <= 1'b0;
      end

      if (process) begin
        out_valid   <= 1'b1;
        raw_last    <= raw_last_next;
        raw_time    <= raw_time_next;
        stable      <= stable_next;
        stable_time <= stable_time_next;
        supp        <= supp_next;
        rel_time    <= rel_time_next;
        pend        <= pend_next;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_func   <= s_tuser;
      in_now    <= s_tdata[31:0];
      in_matrix <= s_tdata[39:32];
    end
    if (process) begin
      out_data <= {supp_next != CODE_NONE, stable_next, ev_next};
    end
  end

  `ASSERT_IMPLY(a_supp_no_part, 1'b1, supp != CODE_WIFI && supp != CODE_TOTAL,
    "single chord key held off instead of the chord")
  `ASSERT_IMPLY(a_rel_idle, supp == CODE_NONE, rel_time == '0,
    "release time kept with nothing held off")
  `ASSERT_IMPLY(a_codes_range, 1'b1, pend <= CODE_CHORD && stable <= CODE_CHORD,
    "key code out of range")
  `ASSERT_NEXT(a_take_clears, process && in_func == FUNC_TAKE, pend == CODE_NONE,
    "pending event survived a take")
  `ASSERT_NEXT(a_result_follows, process, out_valid,
    "processed command left no result")

endmodule

// File: tb/tb_keypad_debounce_chord_scanner_unit.sv
`timescale 1ns / 100ps

module tb_keypad_debounce_chord_scanner_unit;
  import kdcs_pkg::*;

  localparam logic [1:0] FUNC_UNUSED      = 2'd3;
  localparam logic [7:0] ROW1_BOTH        = 8'h0C;
  localparam logic [7:0] WIFI_BIT         = 8'h04;
  localparam logic [7:0] TOTAL_BIT        = 8'h08;
  localparam int         LONG_HOLD_CYCLES = 400;

  typedef struct {
    logic [1:0]  func;
    logic [31:0] now_ms;
    logic [7:0]  keys;
  } key_cmd_t;

  typedef struct {
    code_t ev_code;
    code_t key_code;
    logic  suppress_on;
  } key_report_t;

  logic        clk;
  logic        rst       = 1'b1;
  logic        s_tvalid  = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata   = '0;
  logic [1:0]  s_tuser   = '0;
  logic        m_tvalid;
  logic        m_tready  = 1'b0;
  logic [15:0] m_tdata;
  logic        cfg_we    = 1'b0;
  logic        cfg_index = 1'b0;
  logic [31:0] cfg_data  = '0;

  key_cmd_t    key_cmds[$];
  key_report_t expected_reports[$];
  key_cmd_t    next_cmd;
  key_report_t want;

  int          fail_count      = 0;
  int          reports_seen    = 0;
  int          queued_in_phase = 0;
  bit          quiet           = 1'b0;
  int          long_hold_req   = 0;
  int          long_hold_seen  = 0;
  int          send_gap        = 0;
  int          stall_left      = 0;
  int          hold_left       = 0;
  logic [31:0] clock_ms        = '0;

  // Scanner copy: configuration and key state
  logic [15:0] cfg_debounce     = DEBOUNCE_RESET;
  logic [31:0] cfg_stuck        = STUCK_RESET;
  code_t       kp_raw_last      = CODE_NONE;
  logic [31:0] kp_raw_since     = '0;
  code_t       kp_stable        = CODE_NONE;
  logic [31:0] kp_stable_since  = '0;
  code_t       kp_blocked       = CODE_NONE;
  logic [31:0] kp_release_since = '0;
  code_t       kp_pending       = CODE_NONE;

  keypad_debounce_chord_scanner_unit DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  function automatic logic [31:0] ms_since(logic [31:0] now, logic [31:0] t);
    return now - t;
  endfunction

  function automatic bit is_chord_key(code_t k);
    return k == CODE_WIFI || k == CODE_TOTAL;
  endfunction

  function automatic bit key_blocked(code_t k);
    return k == kp_blocked || (kp_blocked == CODE_CHORD && is_chord_key(k));
  endfunction

  function automatic bit key_still_down(code_t target, logic [7:0] keys);
    if (target == CODE_NONE) return 1'b0;
    if (target == CODE_CHORD) return (keys & ROW1_BOTH) != 8'h00;
    if (target > CODE_TARE) return 1'b0;
    return keys[target - 4'd1];
  endfunction

  // Row-then-column priority; row 1 fully down is the chord unless it is held off
  function automatic code_t first_free_key(logic [7:0] keys);
    code_t k;
    for (int r = 0; r < 4; r++) begin
      if (r == 1 && (keys & ROW1_BOTH) == ROW1_BOTH &&
          !key_blocked(CODE_WIFI) && !key_blocked(CODE_TOTAL))
        return CODE_CHORD;
      for (int c = 0; c < 2; c++) begin
        k = code_t'(r * 2 + c + 1);
        if (keys[r * 2 + c] && !key_blocked(k)) return k;
      end
    end
    return CODE_NONE;
  endfunction

  function automatic void block_key(code_t k, logic [31:0] now);
    kp_blocked       = is_chord_key(k) ? CODE_CHORD : k;
    kp_release_since = '0;
    kp_raw_last      = CODE_NONE;
    kp_raw_since     = now;
    kp_stable        = CODE_NONE;
    kp_stable_since  = now;
    kp_pending       = CODE_NONE;
  endfunction

  function automatic void tick_keys(logic [31:0] now, logic [7:0] keys);
    code_t raw;
    code_t prev;
    if (kp_blocked != CODE_NONE) begin
      if (key_still_down(kp_blocked, keys)) begin
        kp_release_since = '0;
      end else if (kp_release_since == 32'd0) begin
        // zero doubles as "no release seen", so a release at time zero restarts
        kp_release_since = now;
      end else if (ms_since(now, kp_release_since) >= {16'd0, cfg_debounce}) begin
        kp_blocked       = CODE_NONE;
        kp_release_since = '0;
      end
    end

    raw = first_free_key(keys);
    if (raw != kp_raw_last) begin
      kp_raw_last  = raw;
      kp_raw_since = now;
    end

    if (raw != kp_stable && ms_since(now, kp_raw_since) >= {16'd0, cfg_debounce}) begin
      prev            = kp_stable;
      kp_stable       = raw;
      kp_stable_since = now;
      if (prev == CODE_CHORD) begin
        // chord let go: hold both of its keys off until they are released
        kp_blocked       = CODE_CHORD;
        kp_release_since = '0;
        kp_stable        = CODE_NONE;
        kp_raw_last      = CODE_NONE;
        kp_raw_since     = now;
        kp_pending       = CODE_NONE;
      end else if (kp_stable == CODE_NONE && is_chord_key(prev)) begin
        kp_pending = prev;
      end else if (kp_stable == CODE_CHORD && (prev == CODE_NONE || is_chord_key(prev))) begin
        kp_pending = CODE_CHORD;
      end else if (prev == CODE_NONE && kp_stable != CODE_NONE &&
                   !is_chord_key(kp_stable)) begin
        kp_pending = kp_stable;
      end
    end

    if (kp_stable != CODE_NONE && kp_blocked == CODE_NONE &&
        ms_since(now, kp_stable_since) >= cfg_stuck)
      block_key(kp_stable, now);
  endfunction

  function automatic key_report_t predict_key_report(logic [1:0] f, logic [31:0] now,
                                                     logic [7:0] keys);
    key_report_t r;
    r.ev_code = CODE_NONE;
    case (f)
      FUNC_TICK: tick_keys(now, keys);
      FUNC_WAKE: block_key(first_free_key(keys), now);
      FUNC_TAKE: begin
        r.ev_code  = kp_pending;
        kp_pending = CODE_NONE;
      end
      default: ;
    endcase
    r.key_code    = kp_stable;
    r.suppress_on = kp_blocked != CODE_NONE;
    return r;
  endfunction

  function automatic void log_failure(string msg);
    if (fail_count < 10) $display("%s", msg);
    fail_count++;
  endfunction

  // Stimulus helpers

  task automatic push_cmd(logic [1:0] f, logic [31:0] now, logic [7:0] keys);
    key_cmd_t c;
    c.func   = f;
    c.now_ms = now;
    c.keys   = keys;
    key_cmds.push_back(c);
    queued_in_phase++;
  endtask

  function automatic logic [31:0] ms_step();
    logic [31:0] span;
    span = (cfg_debounce == 16'd0) ? 32'd8 : ({16'd0, cfg_debounce} >> 1) + 32'd1;
    return $urandom_range(span * 2, 0);
  endfunction

  function automatic logic [7:0] key_pattern();
    case ($urandom_range(9, 0))
      0, 1, 2, 3: return 8'(1 << $urandom_range(7, 0));
      4, 5:       return ROW1_BOTH;
      6:          return $urandom_range(1, 0) ? WIFI_BIT : TOTAL_BIT;
      7, 8:       return 8'($urandom);
      default:    return 8'h00;
    endcase
  endfunction

  task automatic queue_gesture();
    int         pick;
    logic [7:0] keys;
    pick = $urandom_range(99, 0);
    keys = key_pattern();
    if (pick < 10) begin
      push_cmd(2'($urandom_range(3, 0)), $urandom, 8'($urandom));
    end else if (pick < 16) begin
      clock_ms += ms_step();
      push_cmd(FUNC_WAKE, clock_ms, keys);
    end else begin
      if (pick < 35) begin
        // contact bounce ahead of the real press
        repeat ($urandom_range(3, 1)) begin
          clock_ms += $urandom_range(3, 0);
          push_cmd(FUNC_TICK, clock_ms, keys);
          clock_ms += 1;
          push_cmd(FUNC_TICK, clock_ms, keys & 8'($urandom));
        end
      end
      repeat ($urandom_range(6, 1)) begin
        clock_ms += ms_step();
        push_cmd(FUNC_TICK, clock_ms, keys);
      end
      if (pick < 45) begin
        clock_ms += cfg_stuck;
        push_cmd(FUNC_TICK, clock_ms, keys);
      end
      if (keys == ROW1_BOTH && $urandom_range(1, 0)) begin
        // let one chord key go first
        repeat ($urandom_range(3, 1)) begin
          clock_ms += ms_step();
          push_cmd(FUNC_TICK, clock_ms, $urandom_range(1, 0) ? WIFI_BIT : TOTAL_BIT);
        end
      end
      repeat ($urandom_range(6, 1)) begin
        clock_ms += ms_step();
        push_cmd(FUNC_TICK, clock_ms, 8'h00);
      end
      if ($urandom_range(9, 0) < 7) push_cmd(FUNC_TAKE, clock_ms, 8'($urandom));
    end
  endtask

  task automatic run_random(int n, logic [31:0] start_ms);
    clock_ms        = start_ms;
    queued_in_phase = 0;
    while (queued_in_phase < n) queue_gesture();
  endtask

  // Wait until every queued command has gone in and every report has come back
  task automatic drain();
    while (key_cmds.size() != 0 || s_tvalid || expected_reports.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(cfg_index_t idx, logic [31:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_DEBOUNCE) cfg_debounce = val[15:0];
    else cfg_stuck = val;
  endtask

  task automatic set_config(logic [31:0] dbn_word, logic [31:0] stuck);
    write_reg(CFG_DEBOUNCE, dbn_word);
    write_reg(CFG_STUCK, stuck);
  endtask

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Sender: one command per transfer, predicted as it is accepted
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready)
        expected_reports.push_back(predict_key_report(s_tuser, s_tdata[31:0],
                                                      s_tdata[39:32]));
      if (!s_tvalid || s_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          s_tvalid <= 1'b0;
        end else if (key_cmds.size() != 0) begin
          next_cmd = key_cmds.pop_front();
          s_tuser  <= next_cmd.func;
          s_tdata  <= {next_cmd.keys, next_cmd.now_ms};
          s_tvalid <= 1'b1;
          if (!quiet && $urandom_range(7, 0) == 0) send_gap = $urandom_range(19, 1);
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random stalls plus the occasional long hold-off
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (long_hold_req != long_hold_seen) begin
        long_hold_seen = long_hold_req;
        hold_left      = LONG_HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        if (!quiet && $urandom_range(7, 0) == 0) stall_left = $urandom_range(19, 1);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (expected_reports.size() == 0) begin
        log_failure($sformatf("Report %0d: unexpected transfer, tdata %h",
                              reports_seen, m_tdata));
      end else begin
        want = expected_reports.pop_front();
        if (m_tdata[3:0] !== want.ev_code || m_tdata[7:4] !== want.key_code ||
            m_tdata[8] !== want.suppress_on)
          log_failure($sformatf(
            "Report %0d: event %0d (exp %0d), key %0d (exp %0d), suppress %b (exp %b)",
            reports_seen, m_tdata[3:0], want.ev_code, m_tdata[7:4], want.key_code,
            m_tdata[8], want.suppress_on));
      end
      reports_seen++;
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed: presses, releases, chord, wake, take, wrap and the zero release stamp
    push_cmd(FUNC_TICK,   32'd0,      8'h00);
    push_cmd(FUNC_TICK,   32'd10,     8'h01);
    push_cmd(FUNC_TICK,   32'd60,     8'h01);
    push_cmd(FUNC_TAKE,   32'd60,     8'hFF);
    push_cmd(FUNC_TAKE,   32'd61,     8'h00);
    push_cmd(FUNC_TICK,   32'd70,     8'h00);
    push_cmd(FUNC_TICK,   32'd120,    8'h00);
    push_cmd(FUNC_TICK,   32'd130,    ROW1_BOTH);
    push_cmd(FUNC_TICK,   32'd180,    ROW1_BOTH);
    push_cmd(FUNC_TAKE,   32'd181,    8'h00);
    push_cmd(FUNC_TICK,   32'd190,    8'h00);
    push_cmd(FUNC_TICK,   32'd240,    8'h00);
    push_cmd(FUNC_TICK,   32'd250,    WIFI_BIT);
    push_cmd(FUNC_TICK,   32'd300,    8'h00);
    push_cmd(FUNC_TICK,   32'd350,    8'h00);
    push_cmd(FUNC_TICK,   32'd360,    TOTAL_BIT);
    push_cmd(FUNC_TICK,   32'd410,    TOTAL_BIT);
    push_cmd(FUNC_TICK,   32'd470,    8'h00);
    push_cmd(FUNC_TAKE,   32'd470,    8'h00);
    push_cmd(FUNC_TICK,   32'd480,    8'h80);
    push_cmd(FUNC_TICK,   32'd530,    8'h80);
    push_cmd(FUNC_WAKE,   32'd540,    8'hFF);
    push_cmd(FUNC_UNUSED, 32'hFFFF_FFFF, 8'hAA);
    push_cmd(FUNC_TICK,   32'hFFFF_FFF0, 8'h01);
    push_cmd(FUNC_TICK,   32'd0,      8'h00);
    push_cmd(FUNC_TICK,   32'd48,     8'h00);
    push_cmd(FUNC_TICK,   32'd96,     8'h00);
    push_cmd(FUNC_TICK,   32'd200,    8'h40);
    push_cmd(FUNC_TICK,   32'd15300,  8'h40);
    push_cmd(FUNC_TAKE,   32'd15400,  8'h00);
    drain();

    set_config({16'($urandom), 16'd5}, 32'd300);
    run_random(280, $urandom);
    // stall the results while commands keep coming, so the input backs up
    while (key_cmds.size() > 150) @(posedge clk);
    long_hold_req++;
    drain();

    set_config(32'd0, 32'd20);
    run_random(280, 32'd0);
    drain();

    set_config({16'($urandom), 16'hFFFF}, 32'hFFFF_FFFF);
    run_random(280, 32'hFFFF_0000);
    drain();

    set_config(32'd1, 32'd1);
    run_random(280, $urandom);
    drain();

    set_config(32'd40, 32'd0);
    run_random(100, $urandom);
    drain();

    quiet = 1'b1;
    set_config(32'd12, 32'd2000);
    run_random(280, $urandom);
    drain();

    repeat (8) @(posedge clk);
    if (fail_count == 0 && expected_reports.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

  initial begin
    #(20_000_000);
    $display("Test completed with failures");
    $finish;
  end

endmodule
